// ===== rtl/ypr_pkg.sv =====
`timescale 1ns / 1ps

// Shared types and constants of the yaw-pitch-roll rotation matrix block.
package ypr_pkg;

   // CORDIC sizing: 30 rotation steps, Q30 sine and cosine with headroom.
   localparam int CordicIters = 30;
   localparam int CordicW     = 34;
   localparam int TurnW       = 32;
   localparam int ProdW       = 68;

   // Start value of x, the inverse CORDIC gain in Q30.
   localparam logic signed [CordicW-1:0] CordicGain = 34'sd652032874;

   // Arctangent of 2^-i in units of 2^-32 of a turn.
   localparam logic [TurnW-1:0] AtanTurn [CordicIters] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
   };

   // One input word: three binary angles.
   typedef struct packed {
      logic [15:0] yaw_angle;
      logic [15:0] pitch_angle;
      logic [15:0] roll_angle;
   } req_word_type;

   // One result word: the nine matrix entries, row by row.
   typedef struct packed {
      logic signed [15:0] r00;
      logic signed [15:0] r01;
      logic signed [15:0] r02;
      logic signed [15:0] r10;
      logic signed [15:0] r11;
      logic signed [15:0] r12;
      logic signed [15:0] r20;
      logic signed [15:0] r21;
      logic signed [15:0] r22;
   } rsp_word_type;

   // Sine and cosine of one angle in Q30.
   typedef struct packed {
      logic signed [CordicW-1:0] s;
      logic signed [CordicW-1:0] c;
   } sincos_type;

   // Shift right by sh bits, rounding half away from zero.
   function automatic logic signed [ProdW-1:0] round_shift(
      input logic signed [ProdW-1:0] v, input int unsigned sh);
      logic [ProdW-1:0] mag;
      mag = v[ProdW-1] ? ProdW'(-v) : ProdW'(v);
      mag = (mag + (ProdW'(1) << (sh - 1))) >> sh;
      return v[ProdW-1] ? -$signed(mag) : $signed(mag);
   endfunction

endpackage

// ===== rtl/ypr_cordic.sv =====
`timescale 1ns / 1ps

// Three-lane pipelined CORDIC: one rotation step per register stage.
// Lane 0 is yaw, lane 1 pitch, lane 2 roll.
module ypr_cordic #(
   parameter int ANGLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  ypr_pkg::req_word_type         in_word,
   output logic                          out_valid,
   output ypr_pkg::sincos_type [2:0]     out_sc
);

   localparam int Steps   = ypr_pkg::CordicIters;
   localparam int W       = ypr_pkg::CordicW;
   localparam int TW      = ypr_pkg::TurnW;
   localparam int UseBits = (ANGLE_BITS < 16) ? ANGLE_BITS : 16;

   logic [Steps:0]             valid_ff;
   logic signed [W-1:0]        x_ff    [Steps+1][3];
   logic signed [W-1:0]        y_ff    [Steps+1][3];
   logic signed [TW-1:0]       z_ff    [Steps+1][3];
   logic [1:0]                 quad_ff [Steps+1][3];
   logic [TW-1:0]              turn_in [3];
   logic                       out_valid_ff;
   ypr_pkg::sincos_type [2:0]  sc_ff;
   ypr_pkg::sincos_type [2:0]  sc_in;

   // Scale each angle to a 32-bit turn.
   always_comb begin
      turn_in[0] = TW'(in_word.yaw_angle[UseBits-1:0]) << (TW - ANGLE_BITS);
      turn_in[1] = TW'(in_word.pitch_angle[UseBits-1:0]) << (TW - ANGLE_BITS);
      turn_in[2] = TW'(in_word.roll_angle[UseBits-1:0]) << (TW - ANGLE_BITS);
   end

   // Valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= {valid_ff[Steps-1:0], in_valid};
         out_valid_ff <= valid_ff[Steps];
      end
   end

   // Entry stage: split off the quadrant, start the vector on the x axis.
   always_ff @(posedge clock) begin
      for (int l = 0; l < 3; l++) begin
         quad_ff[0][l] <= turn_in[l][TW-1:TW-2];
         z_ff[0][l]    <= {2'b00, turn_in[l][TW-3:0]};
         x_ff[0][l]    <= ypr_pkg::CordicGain;
         y_ff[0][l]    <= '0;
      end
   end

   // One rotation step per stage, toward z = 0.
   for (genvar i = 0; i < Steps; i++) begin : g_step
      always_ff @(posedge clock) begin
         for (int l = 0; l < 3; l++) begin
            quad_ff[i+1][l] <= quad_ff[i][l];
            if (!z_ff[i][l][TW-1]) begin
               x_ff[i+1][l] <= x_ff[i][l] - (y_ff[i][l] >>> i);
               y_ff[i+1][l] <= y_ff[i][l] + (x_ff[i][l] >>> i);
               z_ff[i+1][l] <= z_ff[i][l] - $signed(ypr_pkg::AtanTurn[i]);
            end else begin
               x_ff[i+1][l] <= x_ff[i][l] + (y_ff[i][l] >>> i);
               y_ff[i+1][l] <= y_ff[i][l] - (x_ff[i][l] >>> i);
               z_ff[i+1][l] <= z_ff[i][l] + $signed(ypr_pkg::AtanTurn[i]);
            end
         end
      end
   end

   // Fold the first-quadrant result back to the full turn.
   always_comb begin
      for (int l = 0; l < 3; l++) begin
         case (quad_ff[Steps][l])
            2'd0: begin
               sc_in[l].s = y_ff[Steps][l];
               sc_in[l].c = x_ff[Steps][l];
            end
            2'd1: begin
               sc_in[l].s = x_ff[Steps][l];
               sc_in[l].c = -y_ff[Steps][l];
            end
            2'd2: begin
               sc_in[l].s = -y_ff[Steps][l];
               sc_in[l].c = -x_ff[Steps][l];
            end
            default: begin
               sc_in[l].s = -x_ff[Steps][l];
               sc_in[l].c = y_ff[Steps][l];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      sc_ff <= sc_in;
   end

   assign out_valid = out_valid_ff;
   assign out_sc    = sc_ff;

endmodule

// ===== rtl/ypr_matrix.sv =====
`timescale 1ns / 1ps

// Product pipeline: forms the nine matrix entries from the sines and cosines.
// Stages: two-factor products, rounding to Q30, third factor, sums, rounding.
module ypr_matrix #(
   parameter int FRAC_BITS = 14
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  ypr_pkg::sincos_type [2:0]     in_sc,
   output logic                          out_valid,
   output ypr_pkg::rsp_word_type         out_word
);

   localparam int W  = ypr_pkg::CordicW;
   localparam int PW = ypr_pkg::ProdW;
   localparam logic signed [PW-1:0] Lim = PW'(1) << FRAC_BITS;

   logic [4:0] valid_ff;

   // Stage 1 registers.
   logic signed [PW-1:0] cycz_ff, sysx_ff, sycz_ff, cysz_ff, cysx_ff;
   logic signed [PW-1:0] sysz_ff, czcx_ff, szcx_ff, sycx_ff, cycx_ff;
   logic signed [W-1:0]  cz1_ff, sx1_ff;
   // Stage 2 registers.
   logic signed [W-1:0]  t1_ff, t2_ff, t3_ff, t4_ff, cz2_ff, sx2_ff;
   logic signed [PW-1:0] cycz2_ff, sycz2_ff, cysz2_ff, sysz2_ff;
   logic signed [PW-1:0] czcx2_ff, szcx2_ff, sycx2_ff, cycx2_ff;
   // Stage 3 registers.
   logic signed [PW-1:0] ma_ff, mb_ff, mc_ff, md_ff;
   logic signed [PW-1:0] cycz3_ff, sycz3_ff, cysz3_ff, sysz3_ff;
   logic signed [PW-1:0] czcx3_ff, szcx3_ff, sycx3_ff, cycx3_ff;
   logic signed [W-1:0]  sx3_ff;
   // Stage 4 registers: the Q60 entries.
   logic signed [PW-1:0] e_ff [9];
   // Stage 5: the result word.
   ypr_pkg::rsp_word_type word_ff;

   // Round a Q60 entry to the output format and clamp to plus or minus one.
   function automatic logic signed [15:0] finish(input logic signed [PW-1:0] q60);
      logic signed [PW-1:0] v;
      v = ypr_pkg::round_shift(q60, 60 - FRAC_BITS);
      if (v > Lim) begin
         v = Lim;
      end
      if (v < -Lim) begin
         v = -Lim;
      end
      return v[15:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[3:0], in_valid};
      end
   end

   // Stage 1: all two-factor products (z = yaw, x = pitch, y = roll).
   always_ff @(posedge clock) begin
      cycz_ff <= in_sc[2].c * in_sc[0].c;
      sysx_ff <= in_sc[2].s * in_sc[1].s;
      sycz_ff <= in_sc[2].s * in_sc[0].c;
      cysz_ff <= in_sc[2].c * in_sc[0].s;
      cysx_ff <= in_sc[2].c * in_sc[1].s;
      sysz_ff <= in_sc[2].s * in_sc[0].s;
      czcx_ff <= in_sc[0].c * in_sc[1].c;
      szcx_ff <= in_sc[0].s * in_sc[1].c;
      sycx_ff <= in_sc[2].s * in_sc[1].c;
      cycx_ff <= in_sc[2].c * in_sc[1].c;
      cz1_ff  <= in_sc[0].c;
      sx1_ff  <= in_sc[1].s;
   end

   // Stage 2: round the roll products that take a third factor back to Q30.
   always_ff @(posedge clock) begin
      t1_ff    <= W'(ypr_pkg::round_shift(sysz_ff, 30));
      t2_ff    <= W'(ypr_pkg::round_shift(cysz_ff, 30));
      t3_ff    <= W'(ypr_pkg::round_shift(sysx_ff, 30));
      t4_ff    <= W'(ypr_pkg::round_shift(cysx_ff, 30));
      cz2_ff   <= cz1_ff;
      sx2_ff   <= sx1_ff;
      cycz2_ff <= cycz_ff;
      sycz2_ff <= sycz_ff;
      cysz2_ff <= cysz_ff;
      sysz2_ff <= sysz_ff;
      czcx2_ff <= czcx_ff;
      szcx2_ff <= szcx_ff;
      sycx2_ff <= sycx_ff;
      cycx2_ff <= cycx_ff;
   end

   // Stage 3: multiply in the third factor.
   always_ff @(posedge clock) begin
      ma_ff    <= t1_ff * sx2_ff;
      mb_ff    <= t2_ff * sx2_ff;
      mc_ff    <= t3_ff * cz2_ff;
      md_ff    <= t4_ff * cz2_ff;
      sx3_ff   <= sx2_ff;
      cycz3_ff <= cycz2_ff;
      sycz3_ff <= sycz2_ff;
      cysz3_ff <= cysz2_ff;
      sysz3_ff <= sysz2_ff;
      czcx3_ff <= czcx2_ff;
      szcx3_ff <= szcx2_ff;
      sycx3_ff <= sycx2_ff;
      cycx3_ff <= cycx2_ff;
   end

   // Stage 4: combine the terms of each entry.
   always_ff @(posedge clock) begin
      e_ff[0] <= cycz3_ff - ma_ff;
      e_ff[1] <= -szcx3_ff;
      e_ff[2] <= sycz3_ff + mb_ff;
      e_ff[3] <= cysz3_ff + mc_ff;
      e_ff[4] <= czcx3_ff;
      e_ff[5] <= sysz3_ff - md_ff;
      e_ff[6] <= -sycx3_ff;
      e_ff[7] <= PW'(sx3_ff) <<< 30;
      e_ff[8] <= cycx3_ff;
   end

   // Stage 5: round and saturate into the result word.
   always_ff @(posedge clock) begin
      word_ff.r00 <= finish(e_ff[0]);
      word_ff.r01 <= finish(e_ff[1]);
      word_ff.r02 <= finish(e_ff[2]);
      word_ff.r10 <= finish(e_ff[3]);
      word_ff.r11 <= finish(e_ff[4]);
      word_ff.r12 <= finish(e_ff[5]);
      word_ff.r20 <= finish(e_ff[6]);
      word_ff.r21 <= finish(e_ff[7]);
      word_ff.r22 <= finish(e_ff[8]);
   end

   assign out_valid = valid_ff[4];
   assign out_word  = word_ff;

`ifndef NO_ASSERTIONS
   // With the default format, entries r00 and r11 of every emitted word lie within plus or minus one.
   a_range: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[4] && FRAC_BITS == 14) |->
         ($signed(word_ff.r11) <= 16'sd16384 && $signed(word_ff.r11) >= -16'sd16384 &&
          $signed(word_ff.r00) <= 16'sd16384 && $signed(word_ff.r00) >= -16'sd16384))
      else $error("matrix entry out of range");
`endif

endmodule

// ===== rtl/ypr_rotation_matrix.sv =====
`timescale 1ns / 1ps

// Yaw-pitch-roll to 3x3 rotation matrix. A word is taken whenever start is
// high; busy is always low, since the block is a free-running pipeline that
// accepts one angle triple every clock cycle. The matrix for a word appears
// on rsp_word with rsp_valid high for one cycle, after one entry stage, 30
// CORDIC stages, one quadrant stage and five product stages. Results must be
// captured in that cycle; the pipeline never waits for the receiver.
module ypr_rotation_matrix #(
   parameter int ANGLE_BITS = 16,
   parameter int FRAC_BITS  = 14
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  ypr_pkg::req_word_type  req_word,
   output logic                   rsp_valid,
   output ypr_pkg::rsp_word_type  rsp_word
);

   localparam int Latency = ypr_pkg::CordicIters + 7;

   logic                      take;
   logic                      sc_valid;
   ypr_pkg::sincos_type [2:0] sc;

   assign busy = 1'b0;
   assign take = start && !busy;

   // Sines and cosines of the three angles.
   ypr_cordic #(
      .ANGLE_BITS (ANGLE_BITS)
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (take),
      .in_word   (req_word),
      .out_valid (sc_valid),
      .out_sc    (sc)
   );

   // Matrix products, rounding and saturation.
   ypr_matrix #(
      .FRAC_BITS (FRAC_BITS)
   ) u_matrix (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sc_valid),
      .in_sc     (sc),
      .out_valid (rsp_valid),
      .out_word  (rsp_word)
   );

`ifndef NO_ASSERTIONS
   // A result only ever follows a word taken through the full pipeline depth.
   a_result_origin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(take, Latency))
      else $error("result without a matching request");

   // The sine and cosine stage is reached by a word only after the entry, CORDIC and quadrant stages.
   a_cordic_timing: assert property (@(posedge clock) disable iff (reset)
      sc_valid |-> $past(take, ypr_pkg::CordicIters + 2))
      else $error("CORDIC output out of step");
`endif

endmodule
